[sv/kms_pkg.sv]
// ----------------------------------------------------------------------------
// kms_pkg
// Shared widths and default sizes for the spanning forest saving block.
// ----------------------------------------------------------------------------
package kms_pkg;

  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_MAX_EDGES = 4096;

  localparam int NODE_W  = 10;
  localparam int COST_W  = 16;
  localparam int SUM_W   = 28;
  localparam int RANK_W  = 4;
  localparam int COUNT_W = 11;

endpackage

[sv/kruskal_mst_saving.sv]
// ----------------------------------------------------------------------------
// kruskal_mst_saving
// Edges load at one beat per cycle, but only in S_LOAD. After the last edge the
// forest RAM is swept over all MAX_NODES entries, then each stored edge costs
// one selection scan over the edge RAM, an S_FRD/S_FCHK pair per node visited
// on both find paths, and S_JOIN plus S_JOIN2 when equal ranks are merged. The
// result beat is registered in S_DONE once the output register is free.
// Synchronous reset clears the state, edge count, weight sum, drop flag and
// output valid and sets the node count to one; the RAMs are not reset.
// ----------------------------------------------------------------------------
module kruskal_mst_saving #(
  parameter int MAX_NODES = kms_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = kms_pkg::DEF_MAX_EDGES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [kms_pkg::COUNT_W-1:0] cfg_wdata,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // node_a [9:0], node_b [19:10], edge_weight [35:20], zero pad [39:36]
  input  logic [39:0]                 s_axis_tdata,
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tree_weight [27:0], saved_weight [55:28]
  output logic [55:0]                 m_axis_tdata,
  // status [0]
  output logic                        m_axis_tuser
);
  import kms_pkg::*;

  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int NAW = $clog2(MAX_NODES);
  localparam int EDW = COST_W + 2 * NODE_W;
  localparam int FW  = RANK_W + NAW;
  localparam int KW  = COST_W + EAW;

  typedef enum logic [2:0] {
    S_LOAD, S_INIT, S_SCAN, S_FRD, S_FCHK, S_JOIN, S_JOIN2, S_DONE
  } state_t;

  state_t state;

  logic [COUNT_W-1:0] node_count;
  logic [ECW-1:0]     edge_cnt;
  logic [SUM_W-1:0]   weight_sum;
  logic [SUM_W-1:0]   tree_sum;
  logic               bad_seen;
  logic [NAW-1:0]     init_cnt;
  logic [ECW-1:0]     pass_cnt;
  logic [ECW-1:0]     scan_addr;
  logic               scan_pend;
  logic [EAW-1:0]     scan_idx;
  logic               have_best;
  logic               have_prev;
  logic [KW-1:0]      best_key;
  logic [KW-1:0]      prev_key;
  logic [NODE_W-1:0]  best_a;
  logic [NODE_W-1:0]  best_b;
  logic               side;
  logic [NAW-1:0]     cur;
  logic [NAW-1:0]     root_a;
  logic [NAW-1:0]     root_b;
  logic [RANK_W-1:0]  rank_a;
  logic [RANK_W-1:0]  rank_b;

  logic [NODE_W-1:0] in_a, in_b;
  logic [COST_W-1:0] in_w;
  logic              in_fire, in_ok;

  assign in_a    = s_axis_tdata[NODE_W-1:0];
  assign in_b    = s_axis_tdata[2*NODE_W-1:NODE_W];
  assign in_w    = s_axis_tdata[EDW-1:2*NODE_W];
  assign s_axis_tready = (state == S_LOAD);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign in_ok   = ({1'b0, in_a} < node_count) && ({1'b0, in_b} < node_count) &&
                   (32'(in_a) < MAX_NODES) && (32'(in_b) < MAX_NODES) &&
                   (edge_cnt < ECW'(MAX_EDGES));

  // edge store
  logic [EDW-1:0] edge_rdata;
  kms_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES), .AW(EAW)) u_edges (
    .clk   (clk),
    .we    (in_fire && in_ok),
    .waddr (edge_cnt[EAW-1:0]),
    .wdata ({in_w, in_b, in_a}),
    .raddr (scan_addr[EAW-1:0]),
    .rdata (edge_rdata)
  );

  // union-find forest: {rank, parent}
  logic           f_we;
  logic [NAW-1:0] f_waddr;
  logic [FW-1:0]  f_wdata;
  logic [FW-1:0]  f_rdata;
  kms_ram #(.WIDTH(FW), .DEPTH(MAX_NODES), .AW(NAW)) u_forest (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (cur),
    .rdata (f_rdata)
  );

  logic [RANK_W-1:0] rank_b_inc;
  assign rank_b_inc = (rank_b == {RANK_W{1'b1}}) ? rank_b : rank_b + 1'b1;

  always_comb begin
    f_we    = 1'b0;
    f_waddr = init_cnt;
    f_wdata = {{RANK_W{1'b0}}, init_cnt};
    case (state)
      S_INIT: f_we = 1'b1;
      S_JOIN: begin
        if (root_a != root_b) begin
          f_we = 1'b1;
          if (rank_b < rank_a) begin
            f_waddr = root_b;
            f_wdata = {rank_b, root_a};
          end else begin
            f_waddr = root_a;
            f_wdata = {rank_a, root_b};
          end
        end
      end
      S_JOIN2: begin
        f_we    = 1'b1;
        f_waddr = root_b;
        f_wdata = {rank_b_inc, root_b};
      end
      default: f_we = 1'b0;
    endcase
  end

  // selection: smallest {cost, index} strictly above the previous pick
  logic [KW-1:0] rd_key;
  logic          rd_take;
  assign rd_key  = {edge_rdata[EDW-1:2*NODE_W], scan_idx};
  assign rd_take = scan_pend && (!have_prev || rd_key > prev_key) &&
                   (!have_best || rd_key < best_key);

  logic [NAW-1:0] rd_parent;
  assign rd_parent = f_rdata[NAW-1:0];

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      node_count    <= COUNT_W'(1);
      edge_cnt      <= '0;
      weight_sum    <= '0;
      bad_seen      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      scan_pend     <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (in_ok) begin
              edge_cnt   <= edge_cnt + 1'b1;
              weight_sum <= weight_sum + SUM_W'(in_w);
            end else begin
              bad_seen <= 1'b1;
            end
            if (s_axis_tlast) begin
              init_cnt <= '0;
              state    <= S_INIT;
            end
          end
        end
        S_INIT: begin
          init_cnt <= init_cnt + 1'b1;
          if (init_cnt == NAW'(MAX_NODES - 1)) begin
            tree_sum  <= '0;
            pass_cnt  <= '0;
            have_prev <= 1'b0;
            have_best <= 1'b0;
            scan_addr <= '0;
            scan_pend <= 1'b0;
            state     <= (edge_cnt == '0) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          scan_idx  <= scan_addr[EAW-1:0];
          scan_pend <= (scan_addr != edge_cnt);
          if (scan_addr != edge_cnt) begin
            scan_addr <= scan_addr + 1'b1;
          end
          if (rd_take) begin
            have_best <= 1'b1;
            best_key  <= rd_key;
            best_a    <= edge_rdata[NODE_W-1:0];
            best_b    <= edge_rdata[2*NODE_W-1:NODE_W];
          end
          if (scan_addr == edge_cnt && !scan_pend) begin
            side  <= 1'b0;
            cur   <= NAW'(best_a);
            state <= S_FRD;
          end
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (rd_parent == cur) begin
            if (!side) begin
              root_a <= cur;
              rank_a <= f_rdata[FW-1:NAW];
              side   <= 1'b1;
              cur    <= NAW'(best_b);
              state  <= S_FRD;
            end else begin
              root_b <= cur;
              rank_b <= f_rdata[FW-1:NAW];
              state  <= S_JOIN;
            end
          end else begin
            cur   <= rd_parent;
            state <= S_FRD;
          end
        end
        S_JOIN, S_JOIN2: begin
          if (state == S_JOIN && root_a != root_b) begin
            tree_sum <= tree_sum + SUM_W'(best_key[KW-1:EAW]);
          end
          if (state == S_JOIN && root_a != root_b && rank_a == rank_b) begin
            state <= S_JOIN2;
          end else begin
            pass_cnt  <= pass_cnt + 1'b1;
            prev_key  <= best_key;
            have_prev <= 1'b1;
            have_best <= 1'b0;
            scan_addr <= '0;
            scan_pend <= 1'b0;
            state     <= (pass_cnt + 1'b1 == edge_cnt) ? S_DONE : S_SCAN;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {weight_sum - tree_sum, tree_sum};
            m_axis_tuser  <= bad_seen;
            edge_cnt      <= '0;
            weight_sum    <= '0;
            bad_seen      <= 1'b0;
            state         <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    edge_cnt <= ECW'(MAX_EDGES))
    else $error("edge count beyond store depth");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (edge_cnt == '0 && weight_sum == '0 && !bad_seen))
    else $error("graph state not cleared after result");

  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_FCHK) |-> (pass_cnt < edge_cnt))
    else $error("more passes than stored edges");

  a_result_beat: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> m_axis_tvalid)
    else $error("result beat not offered");
`endif

endmodule

[sv/kms_ram.sv]
// ----------------------------------------------------------------------------
// kms_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spanning forest saving testbench
// Streams edge graphs into kruskal_mst_saving under several node counts,
// predicts the forest weight, saving and drop flag per graph in a scoreboard,
// and checks each result beat in order with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import kms_pkg::*;

  localparam int MAXN = DEF_MAX_NODES;
  localparam int MAXE = DEF_MAX_EDGES;
  localparam longint CYCLE_LIMIT = 4000000;

  class forest_scoreboard;
    int unsigned node_count;
    int unsigned ends_a[$], ends_b[$], costs[$];
    bit [SUM_W-1:0] weight_sum;
    bit dropped;
    bit [SUM_W-1:0] tree_q[$], saved_q[$];
    bit status_q[$];
    int mismatches, graphs;

    function new();
      node_count = 1;
      clear_graph();
      mismatches = 0;
      graphs = 0;
    endfunction

    function void clear_graph();
      ends_a.delete();
      ends_b.delete();
      costs.delete();
      weight_sum = '0;
      dropped = 0;
    endfunction

    function bit empty();
      return tree_q.size() == 0;
    endfunction

    function bit [SUM_W-1:0] forest_weight();
      int unsigned ord[$];
      int unsigned parent[MAXN];
      int unsigned rnk[MAXN];
      int unsigned j, k, tmp, ra, rb;
      bit [SUM_W-1:0] total;
      total = '0;
      for (int i = 0; i < MAXN; i++) begin
        parent[i] = i;
        rnk[i] = 0;
      end
      // stable insertion sort by cost
      for (int i = 0; i < costs.size(); i++) begin
        ord = {ord, unsigned'(i)};
        j = i;
        while (j > 0 && costs[ord[j-1]] > costs[ord[j]]) begin
          tmp = ord[j]; ord[j] = ord[j-1]; ord[j-1] = tmp;
          j--;
        end
      end
      foreach (ord[i]) begin
        k = ord[i];
        ra = ends_a[k];
        while (parent[ra] != ra) ra = parent[ra];
        rb = ends_b[k];
        while (parent[rb] != rb) rb = parent[rb];
        if (ra != rb) begin
          if (rnk[ra] < rnk[rb]) parent[ra] = rb;
          else if (rnk[rb] < rnk[ra]) parent[rb] = ra;
          else begin
            parent[ra] = rb;
            if (rnk[rb] < 15) rnk[rb]++;
          end
          total = total + SUM_W'(costs[k]);
        end
      end
      return total;
    endfunction

    function void note_edge(int unsigned a, int unsigned b, int unsigned w, bit last);
      int unsigned n;
      bit [SUM_W-1:0] t;
      n = (node_count > MAXN) ? MAXN : node_count;
      if (a >= n || b >= n || costs.size() >= MAXE) begin
        dropped = 1;
      end else begin
        ends_a = {ends_a, a};
        ends_b = {ends_b, b};
        costs = {costs, w};
        weight_sum = weight_sum + SUM_W'(w);
      end
      if (last) begin
        t = forest_weight();
        tree_q = {tree_q, t};
        saved_q = {saved_q, weight_sum - t};
        status_q = {status_q, dropped};
        graphs++;
        clear_graph();
      end
    endfunction

    function void check_result(bit [55:0] data, bit flag);
      bit [SUM_W-1:0] et, es;
      bit est;
      if (tree_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result beat %h", data);
        return;
      end
      et = tree_q.pop_front();
      es = saved_q.pop_front();
      est = status_q.pop_front();
      if (data[27:0] !== et || data[55:28] !== es || flag !== est) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: tree %0d/%0d saved %0d/%0d status %0d/%0d (exp/act)",
                   et, data[27:0], es, data[55:28], est, flag);
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;
  logic s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [39:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [55:0] m_axis_tdata;

  forest_scoreboard sb;
  bit quiet;
  longint cycles;
  int edges_sent;

  kruskal_mst_saving dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);

  // receiver stalls in short bursts
  initial begin
    m_axis_tready = 0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        m_axis_tready = 1;
      end
    end
  end

  task automatic send_edge(int unsigned a, int unsigned b, int unsigned w, bit last);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid = 1;
    s_axis_tdata = {4'b0, w[15:0], b[9:0], a[9:0]};
    s_axis_tlast = last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_edge(a, b, w, last);
    edges_sent++;
    if (edges_sent > 1650) quiet = 1;
    @(negedge clk);
    s_axis_tvalid = 0;
  endtask

  task automatic wait_drained();
    while (!sb.empty()) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_node_count(int unsigned n);
    wait_drained();
    cfg_we = 1;
    cfg_wdata = n[COUNT_W-1:0];
    @(posedge clk);
    sb.node_count = n;
    @(negedge clk);
    cfg_we = 0;
  endtask

  // mostly in-range edges; bad_pct percent draw both ends from 0 to 1023
  task automatic random_graph(int unsigned n, int unsigned len, int unsigned bad_pct);
    int unsigned a, b, lim, w;
    lim = (n > MAXN) ? MAXN : n;
    for (int i = 0; i < len; i++) begin
      if (lim == 0 || $urandom_range(0, 99) < bad_pct) begin
        a = $urandom_range(0, 1023);
        b = $urandom_range(0, 1023);
      end else begin
        a = $urandom_range(0, lim - 1);
        b = $urandom_range(0, lim - 1);
      end
      case ($urandom_range(0, 3))
        0: w = $urandom_range(0, 15);
        1: w = $urandom_range(65520, 65535);
        default: w = $urandom_range(0, 65535);
      endcase
      send_edge(a, b, w, i == len - 1);
    end
  endtask

  initial begin
    int unsigned n, len;
    sb = new();
    quiet = 0;
    cycles = 0;
    edges_sent = 0;
    rst = 1;
    cfg_we = 0;
    cfg_wdata = '0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tlast = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // reset count of one: self loop, then a dropped edge alone
    send_edge(0, 0, 65535, 1);
    send_edge(1, 0, 9, 1);
    set_node_count(1024);
    send_edge(1023, 0, 0, 0);
    send_edge(0, 1023, 65535, 0);
    send_edge(5, 5, 7, 0);
    send_edge(1023, 1023, 100, 0);
    send_edge(682, 341, 21845, 0);
    send_edge(341, 682, 43690, 1);
    set_node_count(0);
    send_edge(0, 0, 1, 0);
    send_edge(3, 4, 2, 1);
    set_node_count(2047);
    send_edge(1023, 512, 65535, 0);
    send_edge(512, 1023, 1, 1);
    set_node_count(4);
    send_edge(0, 1, 3, 0);
    send_edge(1, 2, 3, 0);
    send_edge(0, 2, 3, 0);
    send_edge(2, 3, 5, 0);
    send_edge(4, 0, 1, 1);

    while (edges_sent < 1850) begin
      case ($urandom_range(0, 5))
        0: n = 1024;
        1: n = $urandom_range(1025, 2047);
        2: n = $urandom_range(0, 3);
        default: n = $urandom_range(2, 40);
      endcase
      set_node_count(n);
      repeat ($urandom_range(3, 10)) begin
        if (edges_sent < 1850) begin
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 20);
          random_graph(n, len, ($urandom_range(0, 3) == 0) ? 15 : 0);
        end
      end
    end

    while (!sb.empty()) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d graphs from %0d edge beats, node counts 0 to 2047.",
             sb.graphs, edges_sent);
    if (sb.mismatches == 0 && sb.empty())
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
